@@ sv/lspf_pkg.sv @@
// Shared constants for the laser shadow point filter: register map and arithmetic settings.
package lspf_pkg;

   // Register map of the configuration port.
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = 2;

   localparam logic [CSR_IDX_BITS-1:0] REG_COS_MIN = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_COS_MAX = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_WINDOW  = 2'd2;

   // Register widths and reset values.
   localparam int COS_BITS = 16;
   localparam int WIN_BITS = 4;

   localparam logic signed [COS_BITS-1:0] COS_MIN_RESET = 16'sd32270;
   localparam logic signed [COS_BITS-1:0] COS_MAX_RESET = -16'sd32270;
   localparam logic [WIN_BITS-1:0]        WINDOW_RESET  = 4'd2;

   // Tag width, squared cosine width and the Q1.15 scale squared (2^30).
   localparam int TAG_BITS  = 16;
   localparam int CSQ_BITS  = 31;
   localparam int COS_SHIFT = 30;

   // Bits of the multiplier operand retired per cycle by the shared multiplier.
   localparam int DIGIT_BITS = 4;

endpackage

@@ sv/laser_shadow_point_filter.sv @@
// Top level of the laser shadow point filter with its line store and shared multiplier.
// A point is judged after its window of later points arrives; each judgement runs
// on one shared multiplier that retires 4 operand bits per cycle, and a point is checked
// against up to 2*W neighbours; end of scan judges up to W+1 points.
// Throughput: one item at a time; req_ready is high only while the sequencer is idle.
// Reset: synchronous, active high; clears control, registers and counts, no clearing pass.
module laser_shadow_point_filter
   import lspf_pkg::*;
#(
   parameter int MAX_WINDOW = 8,
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   // Input item channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_x_coord,
   input  logic signed [COORD_BITS-1:0] req_y_coord,
   input  logic signed [COORD_BITS-1:0] req_z_coord,
   input  logic [TAG_BITS-1:0]          req_tag,
   input  logic                         req_last_in,
   // Result item channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   output logic signed [COORD_BITS-1:0] rsp_out_z,
   output logic [TAG_BITS-1:0]          rsp_out_tag,
   output logic                         rsp_has_point,
   output logic                         rsp_end_of_scan,
   // Configuration port
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [CSR_ADDR_BITS-1:0]     paddr,
   input  logic [CSR_DATA_BITS-1:0]     pwdata,
   output logic [CSR_DATA_BITS-1:0]     prdata,
   output logic                         pready
);

   localparam int C     = COORD_BITS;
   localparam int DEPTH = 2 * MAX_WINDOW + 1;
   localparam int IW    = $clog2(DEPTH);
   localparam int PSW   = $clog2(DEPTH + 1);
   localparam int KW    = $clog2(MAX_WINDOW + 1);
   localparam int EW    = 3 * C + TAG_BITS;
   localparam int SW    = 2 * C + 4;
   localparam int DOTW  = 2 * C + 3;
   localparam int ABW   = 4 * C + 8;
   localparam int CW    = 4 * C + 40;
   localparam int PW    = (SW > CSQ_BITS) ? SW : CSQ_BITS;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD_I  = 4'd1;
   localparam logic [3:0] S_LD_I  = 4'd2;
   localparam logic [3:0] S_SA    = 4'd3;
   localparam logic [3:0] S_CHKJ  = 4'd4;
   localparam logic [3:0] S_RD_J  = 4'd5;
   localparam logic [3:0] S_LD_J  = 4'd6;
   localparam logic [3:0] S_SB    = 4'd7;
   localparam logic [3:0] S_DOT   = 4'd8;
   localparam logic [3:0] S_DSQ   = 4'd9;
   localparam logic [3:0] S_AB    = 4'd10;
   localparam logic [3:0] S_RMIN  = 4'd11;
   localparam logic [3:0] S_RMAX  = 4'd12;
   localparam logic [3:0] S_KEPT  = 4'd13;
   localparam logic [3:0] S_NEXTK = 4'd14;
   localparam logic [3:0] S_FINAL = 4'd15;

   // Configuration registers and squared cosine limits.
   logic signed [COS_BITS-1:0] cos_min_ff, cos_max_ff;
   logic [WIN_BITS-1:0]        window_ff;
   logic [CSQ_BITS-1:0]        csq_min_ff, csq_max_ff;
   logic [COS_BITS-1:0]        cmag_min, cmag_max;
   logic [31:0]                csq_min_full, csq_max_full;
   logic                       csr_wr;
   logic [CSR_IDX_BITS-1:0]    csr_idx;

   // Line store.
   logic [EW-1:0] line_mem [DEPTH];
   logic [EW-1:0] rd_data_ff;
   logic [IW-1:0] rd_addr;
   logic [PSW-1:0] rd_idx;

   // Shared multiplier.
   logic [CW-1:0] mul_acc_ff, mul_cand_ff;
   logic [PW-1:0] mul_plier_ff;
   logic          mul_busy_ff;
   logic          mul_start;
   logic [CW-1:0] mul_start_cand;
   logic [PW-1:0] mul_start_plier;
   logic          mul_done;

   // Sequencer registers.
   logic [3:0]      state_ff, state_in;
   logic [KW-1:0]   k_ff, k_in;
   logic [KW-1:0]   win_ff, win_in;
   logic [PSW-1:0]  j_ff, j_in;
   logic [PSW-1:0]  jhi_ff, jhi_in;
   logic [PSW-1:0]  ps_ff, ps_in;
   logic [IW-1:0]   wptr_ff, wptr_in;
   logic [1:0]      n_ff, n_in;
   logic            wait_ff, wait_in;
   logic            flush_ff, flush_in;
   logic            pend_valid_ff, pend_valid_in;
   logic [EW-1:0]   pend_ff, pend_in;
   logic [EW-1:0]   pi_ff, pi_in;
   logic [C-1:0]    a_mag_ff [3];
   logic [C-1:0]    a_mag_in [3];
   logic            a_neg_ff [3];
   logic            a_neg_in [3];
   logic [C:0]      b_mag_ff [3];
   logic [C:0]      b_mag_in [3];
   logic            b_neg_ff [3];
   logic            b_neg_in [3];
   logic [SW-1:0]   sa_ff, sa_in, sb_ff, sb_in;
   logic signed [DOTW-1:0] dot_ff, dot_in;
   logic [ABW-1:0]  ab_ff, ab_in;
   logic [CW-1:0]   q_ff, q_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [EW-1:0]   out_ff, out_in;
   logic            has_ff, has_in;
   logic            eos_ff, eos_in;

   // Helper values.
   logic [KW-1:0]   win_clamp, win_use;
   logic [PSW-1:0]  ps_new, k_sum;
   logic [IW-1:0]   wptr_next;
   logic [DOTW-1:0] dmag;
   logic            dpos, dneg;
   logic            slot_free, accept;
   logic [SW-1:0]   sq_sum;
   logic            rej_min, rej_max, q_gt, acc_gt;
   logic [EW-1:0]   req_entry;
   logic [C:0]      b_s [3];

   assign req_entry = {req_tag, req_z_coord, req_y_coord, req_x_coord};
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Configuration write and read.
   assign csr_idx = paddr[CSR_IDX_BITS+1:2];
   assign csr_wr  = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_min_ff <= COS_MIN_RESET;
         cos_max_ff <= COS_MAX_RESET;
         window_ff  <= WINDOW_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_COS_MIN: cos_min_ff <= pwdata[COS_BITS-1:0];
            REG_COS_MAX: cos_max_ff <= pwdata[COS_BITS-1:0];
            REG_WINDOW:  window_ff  <= pwdata[WIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_COS_MIN: prdata = {{(CSR_DATA_BITS-COS_BITS){cos_min_ff[COS_BITS-1]}}, cos_min_ff};
         REG_COS_MAX: prdata = {{(CSR_DATA_BITS-COS_BITS){cos_max_ff[COS_BITS-1]}}, cos_max_ff};
         REG_WINDOW:  prdata = {{(CSR_DATA_BITS-WIN_BITS){1'b0}}, window_ff};
         default:     prdata = '0;
      endcase
   end

   // Squared cosine limits, registered once per cycle from the settings.
   assign cmag_min     = cos_min_ff[COS_BITS-1] ? COS_BITS'(-cos_min_ff) : cos_min_ff;
   assign cmag_max     = cos_max_ff[COS_BITS-1] ? COS_BITS'(-cos_max_ff) : cos_max_ff;
   assign csq_min_full = 32'(cmag_min) * 32'(cmag_min);
   assign csq_max_full = 32'(cmag_max) * 32'(cmag_max);

   always_ff @(posedge clock) begin
      csq_min_ff <= csq_min_full[CSQ_BITS-1:0];
      csq_max_ff <= csq_max_full[CSQ_BITS-1:0];
   end

   // Line store: a circular buffer whose newest entry sits at wptr.
   always_comb begin
      rd_idx = (state_ff == S_RD_I) ? PSW'(k_ff) : j_ff;
      if ({1'b0, wptr_ff} >= (IW+1)'(rd_idx)) begin
         rd_addr = IW'({1'b0, wptr_ff} - (IW+1)'(rd_idx));
      end else begin
         rd_addr = IW'({1'b0, wptr_ff} + (IW+1)'(DEPTH) - (IW+1)'(rd_idx));
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         line_mem[wptr_next] <= req_entry;
      end
      rd_data_ff <= line_mem[rd_addr];
   end

   // Shared multiplier: one digit of the multiplier operand per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_busy_ff <= 1'b0;
      end else if (mul_start) begin
         mul_busy_ff <= 1'b1;
      end else if (mul_busy_ff && (mul_plier_ff == '0)) begin
         mul_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_start) begin
         mul_acc_ff   <= '0;
         mul_cand_ff  <= mul_start_cand;
         mul_plier_ff <= mul_start_plier;
      end else if (mul_busy_ff && (mul_plier_ff != '0)) begin
         mul_acc_ff   <= mul_acc_ff + mul_cand_ff * CW'(mul_plier_ff[DIGIT_BITS-1:0]);
         mul_cand_ff  <= mul_cand_ff << DIGIT_BITS;
         mul_plier_ff <= mul_plier_ff >> DIGIT_BITS;
      end
   end

   assign mul_done = wait_ff && !mul_busy_ff;

   // Operand selection for the multiplier by sequencer state.
   always_comb begin
      mul_start       = !wait_ff;
      mul_start_cand  = '0;
      mul_start_plier = '0;
      unique case (state_ff)
         S_SA: begin
            mul_start_cand  = CW'(a_mag_ff[n_ff]);
            mul_start_plier = PW'(a_mag_ff[n_ff]);
         end
         S_SB: begin
            mul_start_cand  = CW'(b_mag_ff[n_ff]);
            mul_start_plier = PW'(b_mag_ff[n_ff]);
         end
         S_DOT: begin
            mul_start_cand  = CW'(a_mag_ff[n_ff]);
            mul_start_plier = PW'(b_mag_ff[n_ff]);
         end
         S_DSQ: begin
            mul_start_cand  = CW'(dmag);
            mul_start_plier = PW'(dmag);
         end
         S_AB: begin
            mul_start_cand  = CW'(sa_ff);
            mul_start_plier = PW'(sb_ff);
         end
         S_RMIN: begin
            mul_start_cand  = CW'(ab_ff);
            mul_start_plier = PW'(csq_min_ff);
         end
         S_RMAX: begin
            mul_start_cand  = CW'(ab_ff);
            mul_start_plier = PW'(csq_max_ff);
         end
         default: mul_start = 1'b0;
      endcase
   end

   // Dot product sign and magnitude, and the angle limit decisions.
   assign dneg   = dot_ff[DOTW-1];
   assign dpos   = !dot_ff[DOTW-1] && (dot_ff != '0);
   assign dmag   = dneg ? DOTW'(-dot_ff) : DOTW'(dot_ff);
   assign q_gt   = q_ff > mul_acc_ff;
   assign acc_gt = mul_acc_ff > q_ff;
   assign rej_min = cos_min_ff[COS_BITS-1] ? (!dneg || acc_gt) : (dpos && q_gt);
   assign rej_max = (!cos_max_ff[COS_BITS-1] && (cos_max_ff != '0)) ? (!dpos || acc_gt)
                                                                    : (dneg && q_gt);
   assign sq_sum = (state_ff == S_SA) ? sa_ff + mul_acc_ff[SW-1:0]
                                      : sb_ff + mul_acc_ff[SW-1:0];

   // Window clamp and store bookkeeping for a new item.
   always_comb begin
      if (window_ff == '0) begin
         win_clamp = KW'(1);
      end else if (int'(window_ff) > MAX_WINDOW) begin
         win_clamp = KW'(MAX_WINDOW);
      end else begin
         win_clamp = KW'(window_ff);
      end
      win_use   = (ps_ff == '0) ? win_clamp : win_ff;
      ps_new    = (int'(ps_ff) < DEPTH) ? ps_ff + PSW'(1) : ps_ff;
      wptr_next = (int'(wptr_ff) == DEPTH - 1) ? '0 : wptr_ff + IW'(1);
      k_sum     = PSW'(k_ff) + PSW'(win_ff);
   end

   // Neighbour difference vectors from the point under test.
   always_comb begin
      for (int n = 0; n < 3; n++) begin
         b_s[n] = {rd_data_ff[n*C+C-1], rd_data_ff[n*C +: C]}
                - {pi_ff[n*C+C-1], pi_ff[n*C +: C]};
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      win_in        = win_ff;
      j_in          = j_ff;
      jhi_in        = jhi_ff;
      ps_in         = ps_ff;
      wptr_in       = wptr_ff;
      n_in          = n_ff;
      wait_in       = wait_ff;
      flush_in      = flush_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      pi_in         = pi_ff;
      a_mag_in      = a_mag_ff;
      a_neg_in      = a_neg_ff;
      b_mag_in      = b_mag_ff;
      b_neg_in      = b_neg_ff;
      sa_in         = sa_ff;
      sb_in         = sb_ff;
      dot_in        = dot_ff;
      ab_in         = ab_ff;
      q_in          = q_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      out_in        = out_ff;
      has_in        = has_ff;
      eos_in        = eos_ff;

      if (mul_start) begin
         wait_in = 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               win_in   = win_use;
               ps_in    = ps_new;
               wptr_in  = wptr_next;
               flush_in = req_last_in;
               if (req_last_in) begin
                  k_in     = (PSW'(win_use) > ps_new - PSW'(1)) ? KW'(ps_new - PSW'(1))
                                                                : win_use;
                  state_in = S_RD_I;
               end else if (ps_new > PSW'(win_use)) begin
                  k_in     = win_use;
                  state_in = S_RD_I;
               end
            end
         end
         S_RD_I: state_in = S_LD_I;
         S_LD_I: begin
            pi_in = rd_data_ff;
            for (int n = 0; n < 3; n++) begin
               a_mag_in[n] = rd_data_ff[n*C+C-1] ? C'(-rd_data_ff[n*C +: C])
                                                 : rd_data_ff[n*C +: C];
               a_neg_in[n] = !rd_data_ff[n*C+C-1] && (rd_data_ff[n*C +: C] != '0);
            end
            sa_in  = '0;
            n_in   = '0;
            j_in   = (k_ff >= win_ff) ? PSW'(k_ff - win_ff) : '0;
            jhi_in = (k_sum > ps_ff - PSW'(1)) ? ps_ff - PSW'(1) : k_sum;
            state_in = S_SA;
         end
         S_SA: begin
            if (mul_done) begin
               wait_in = 1'b0;
               sa_in   = sq_sum;
               if (n_ff == 2'd2) begin
                  n_in     = '0;
                  state_in = S_CHKJ;
               end else begin
                  n_in = n_ff + 2'd1;
               end
            end
         end
         S_CHKJ: begin
            if (j_ff > jhi_ff) begin
               state_in = S_KEPT;
            end else if (j_ff == PSW'(k_ff)) begin
               j_in = j_ff + PSW'(1);
            end else begin
               state_in = S_RD_J;
            end
         end
         S_RD_J: state_in = S_LD_J;
         S_LD_J: begin
            for (int n = 0; n < 3; n++) begin
               b_neg_in[n] = b_s[n][C];
               b_mag_in[n] = b_s[n][C] ? (C+1)'(-b_s[n]) : b_s[n];
            end
            sb_in    = '0;
            dot_in   = '0;
            n_in     = '0;
            state_in = S_SB;
         end
         S_SB: begin
            if (mul_done) begin
               wait_in = 1'b0;
               sb_in   = sq_sum;
               if (n_ff == 2'd2) begin
                  n_in = '0;
                  // A zero vector counts as angle zero, which always fails.
                  if ((sa_ff == '0) || (sq_sum == '0)) begin
                     state_in = flush_ff ? S_NEXTK : S_IDLE;
                  end else begin
                     state_in = S_DOT;
                  end
               end else begin
                  n_in = n_ff + 2'd1;
               end
            end
         end
         S_DOT: begin
            if (mul_done) begin
               wait_in = 1'b0;
               if (a_neg_ff[n_ff] != b_neg_ff[n_ff]) begin
                  dot_in = dot_ff - DOTW'(mul_acc_ff);
               end else begin
                  dot_in = dot_ff + DOTW'(mul_acc_ff);
               end
               if (n_ff == 2'd2) begin
                  n_in     = '0;
                  state_in = S_DSQ;
               end else begin
                  n_in = n_ff + 2'd1;
               end
            end
         end
         S_DSQ: begin
            if (mul_done) begin
               wait_in  = 1'b0;
               q_in     = mul_acc_ff << COS_SHIFT;
               state_in = S_AB;
            end
         end
         S_AB: begin
            if (mul_done) begin
               wait_in  = 1'b0;
               ab_in    = mul_acc_ff[ABW-1:0];
               state_in = S_RMIN;
            end
         end
         S_RMIN: begin
            if (mul_done) begin
               wait_in = 1'b0;
               if (rej_min) begin
                  state_in = flush_ff ? S_NEXTK : S_IDLE;
               end else begin
                  state_in = S_RMAX;
               end
            end
         end
         S_RMAX: begin
            if (mul_done) begin
               wait_in = 1'b0;
               if (rej_max) begin
                  state_in = flush_ff ? S_NEXTK : S_IDLE;
               end else begin
                  j_in     = j_ff + PSW'(1);
                  state_in = S_CHKJ;
               end
            end
         end
         S_KEPT: begin
            // During a flush the newest kept point waits, so the last one can carry end of scan.
            if (!flush_ff) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  out_in       = pi_ff;
                  has_in       = 1'b1;
                  eos_in       = 1'b0;
                  state_in     = S_IDLE;
               end
            end else if (pend_valid_ff) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  out_in       = pend_ff;
                  has_in       = 1'b1;
                  eos_in       = 1'b0;
                  pend_in      = pi_ff;
                  state_in     = S_NEXTK;
               end
            end else begin
               pend_in       = pi_ff;
               pend_valid_in = 1'b1;
               state_in      = S_NEXTK;
            end
         end
         S_NEXTK: begin
            if (k_ff == '0) begin
               state_in = S_FINAL;
            end else begin
               k_in     = k_ff - KW'(1);
               state_in = S_RD_I;
            end
         end
         S_FINAL: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               out_in        = pend_valid_ff ? pend_ff : '0;
               has_in        = pend_valid_ff;
               eos_in        = 1'b1;
               pend_valid_in = 1'b0;
               ps_in         = '0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         win_ff        <= KW'(1);
         ps_ff         <= '0;
         wptr_ff       <= '0;
         wait_ff       <= 1'b0;
         flush_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         win_ff        <= win_in;
         ps_ff         <= ps_in;
         wptr_ff       <= wptr_in;
         wait_ff       <= wait_in;
         flush_ff      <= flush_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      j_ff     <= j_in;
      jhi_ff   <= jhi_in;
      n_ff     <= n_in;
      pend_ff  <= pend_in;
      pi_ff    <= pi_in;
      a_mag_ff <= a_mag_in;
      a_neg_ff <= a_neg_in;
      b_mag_ff <= b_mag_in;
      b_neg_ff <= b_neg_in;
      sa_ff    <= sa_in;
      sb_ff    <= sb_in;
      dot_ff   <= dot_in;
      ab_ff    <= ab_in;
      q_ff     <= q_in;
      out_ff   <= out_in;
      has_ff   <= has_in;
      eos_ff   <= eos_in;
   end

   // Result ports.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = out_ff[C-1:0];
   assign rsp_out_y       = out_ff[2*C-1:C];
   assign rsp_out_z       = out_ff[3*C-1:2*C];
   assign rsp_out_tag     = out_ff[EW-1:3*C];
   assign rsp_has_point   = has_ff;
   assign rsp_end_of_scan = eos_ff;

endmodule

@@ sv/lspf_checker.sv @@
// Port-level checks for the laser shadow point filter and their bind.
module lspf_checker
   import lspf_pkg::*;
#(
   parameter int COORD_BITS = 24
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic signed [COORD_BITS-1:0] req_x_coord,
   input logic signed [COORD_BITS-1:0] req_y_coord,
   input logic signed [COORD_BITS-1:0] req_z_coord,
   input logic [TAG_BITS-1:0]          req_tag,
   input logic                         req_last_in,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [COORD_BITS-1:0] rsp_out_x,
   input logic signed [COORD_BITS-1:0] rsp_out_y,
   input logic signed [COORD_BITS-1:0] rsp_out_z,
   input logic [TAG_BITS-1:0]          rsp_out_tag,
   input logic                         rsp_has_point,
   input logic                         rsp_end_of_scan,
   input logic                         psel,
   input logic                         penable,
   input logic                         pwrite,
   input logic [CSR_ADDR_BITS-1:0]     paddr,
   input logic [CSR_DATA_BITS-1:0]     pwdata,
   input logic [CSR_DATA_BITS-1:0]     prdata,
   input logic                         pready
);

   // A stalled result item holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_tag)
         && $stable(rsp_end_of_scan))
      else $error("result item changed while stalled");

   // A waiting input item stays offered with its payload unchanged.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_x_coord) && $stable(req_tag)
         && $stable(req_last_in))
      else $error("input item changed while waiting");

   // A result without a point is only the end-of-scan marker.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_point |-> rsp_end_of_scan)
      else $error("bare result item without end of scan");

   // The end-of-scan marker carries zero point fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_point |-> (rsp_out_x == '0) && (rsp_out_y == '0)
         && (rsp_out_z == '0) && (rsp_out_tag == '0))
      else $error("bare marker with nonzero point fields");

endmodule

bind laser_shadow_point_filter lspf_checker #(.COORD_BITS(COORD_BITS)) u_lspf_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for the laser shadow point filter: directed and random scans.
module tb_top;
   import lspf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAXW  = 8;
   localparam int CBITS = 24;
   localparam int DEPTH = 2 * MAXW + 1;
   localparam int LIMIT = 20_000_000;
   localparam int DRAIN = 16000;

   typedef logic signed [199:0] wide_type;

   typedef struct {
      logic signed [CBITS-1:0] x, y, z;
      logic [TAG_BITS-1:0]     tag;
      logic                    has_point, eos;
   } kept_type;

   logic clock, reset;
   logic req_valid, req_ready, req_last_in;
   logic signed [CBITS-1:0] req_x_coord, req_y_coord, req_z_coord;
   logic [TAG_BITS-1:0] req_tag;
   logic rsp_valid, rsp_ready, rsp_has_point, rsp_end_of_scan;
   logic signed [CBITS-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic [TAG_BITS-1:0] rsp_out_tag;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata, prdata;

   laser_shadow_point_filter #(.MAX_WINDOW(MAXW), .COORD_BITS(CBITS)) dut (.*);

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the filter state and its registers.
   logic signed [CBITS-1:0] ln_x[DEPTH], ln_y[DEPTH], ln_z[DEPTH];
   logic [TAG_BITS-1:0] ln_tag[DEPTH];
   int held_cnt, scan_win;
   longint cfg_cos_lo, cfg_cos_hi;
   int cfg_win;
   kept_type kept_q[$];

   int errors, cycles;
   bit no_idle;
   int hold_seq, hold_len;

   // Append one expected result item.
   function automatic void expect_item(kept_type r);
      kept_q = {kept_q, r};
   endfunction

   // True when D*32768 exceeds c*sqrt(AB), with D as sign and magnitude.
   function automatic bit beyond(int dsig, wide_type dm, longint c, wide_type ab);
      wide_type q, r, cm;
      q  = dm * dm * (wide_type'(1) <<< COS_SHIFT);
      cm = (c < 0) ? wide_type'(-c) : wide_type'(c);
      r  = cm * cm * ab;
      if (c >= 0) begin
         if (dsig <= 0) return 1'b0;
         return q > r;
      end
      if (dsig >= 0) return 1'b1;
      return q < r;
   endfunction

   // Angle test at point i toward neighbour j; zero vectors always reject.
   function automatic bit angle_rejects(int i, int j);
      longint a[3], b[3], sa, sb, dot;
      wide_type ab, dm;
      int dsig;
      a[0] = -longint'(ln_x[i]); a[1] = -longint'(ln_y[i]); a[2] = -longint'(ln_z[i]);
      b[0] = longint'(ln_x[j]) - longint'(ln_x[i]);
      b[1] = longint'(ln_y[j]) - longint'(ln_y[i]);
      b[2] = longint'(ln_z[j]) - longint'(ln_z[i]);
      sa = 0; sb = 0; dot = 0;
      for (int n = 0; n < 3; n++) begin
         sa += a[n] * a[n];
         sb += b[n] * b[n];
         dot += a[n] * b[n];
      end
      if (sa == 0 || sb == 0) return 1'b1;
      dsig = (dot > 0) ? 1 : (dot < 0) ? -1 : 0;
      dm = (dot < 0) ? wide_type'(-dot) : wide_type'(dot);
      ab = wide_type'(sa) * wide_type'(sb);
      if (beyond(dsig, dm, cfg_cos_lo, ab)) return 1'b1;
      if (beyond(-dsig, dm, -cfg_cos_hi, ab)) return 1'b1;
      return 1'b0;
   endfunction

   function automatic bit point_survives(int k);
      int j;
      for (int d = -scan_win; d <= scan_win; d++) begin
         j = k + d;
         if (d == 0 || j < 0 || j >= held_cnt || j >= DEPTH) continue;
         if (angle_rejects(k, j)) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic kept_type kept_at(int k);
      kept_type r;
      r.x = ln_x[k]; r.y = ln_y[k]; r.z = ln_z[k]; r.tag = ln_tag[k];
      r.has_point = 1'b1; r.eos = 1'b0;
      return r;
   endfunction

   // Advance the shadow state by one point and queue the kept points it releases.
   task automatic predict_point(logic signed [CBITS-1:0] x, y, z, logic [TAG_BITS-1:0] tag,
                                logic last);
      int k, n;
      kept_type r;
      if (held_cnt == 0) scan_win = (cfg_win < 1) ? 1 : (cfg_win > MAXW) ? MAXW : cfg_win;
      for (k = DEPTH - 1; k > 0; k--) begin
         ln_x[k] = ln_x[k-1]; ln_y[k] = ln_y[k-1];
         ln_z[k] = ln_z[k-1]; ln_tag[k] = ln_tag[k-1];
      end
      ln_x[0] = x; ln_y[0] = y; ln_z[0] = z; ln_tag[0] = tag;
      if (held_cnt < DEPTH) held_cnt++;
      if (!last) begin
         if (held_cnt > scan_win && point_survives(scan_win)) expect_item(kept_at(scan_win));
         return;
      end
      n = 0;
      k = (scan_win > held_cnt - 1) ? held_cnt - 1 : scan_win;
      for (; k >= 0; k--) begin
         if (point_survives(k)) begin
            expect_item(kept_at(k));
            n++;
         end
      end
      if (n > 0) begin
         kept_q[$].eos = 1'b1;
      end else begin
         r = '{x: '0, y: '0, z: '0, tag: '0, has_point: 1'b0, eos: 1'b1};
         expect_item(r);
      end
      held_cnt = 0;
   endtask

   // Predict on every accepted input item.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         predict_point(req_x_coord, req_y_coord, req_z_coord, req_tag, req_last_in);
   end

   // Compare every accepted result item with the oldest expectation.
   always @(posedge clock) begin
      kept_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (kept_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result item x=%0d tag=%0h", rsp_out_x, rsp_out_tag);
         end else begin
            e = kept_q.pop_front();
            if (rsp_out_x !== e.x || rsp_out_y !== e.y || rsp_out_z !== e.z ||
                rsp_out_tag !== e.tag || rsp_has_point !== e.has_point ||
                rsp_end_of_scan !== e.eos) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp %0d %0d %0d %h h%b e%b got %0d %0d %0d %h h%b e%b",
                           e.x, e.y, e.z, e.tag, e.has_point, e.eos, rsp_out_x, rsp_out_y,
                           rsp_out_z, rsp_out_tag, rsp_has_point, rsp_end_of_scan);
            end
         end
      end
   end

   // Receiver: random stall bursts, plus a long hold-off on request.
   always @(posedge clock) begin
      int stall, seen;
      if (reset) begin
         rsp_ready <= 1'b0;
         seen = hold_seq;
         stall = 0;
      end else if (hold_seq != seen) begin
         seen = hold_seq;
         stall = hold_len;
         rsp_ready <= 1'b0;
      end else if (stall > 0) begin
         stall--;
         rsp_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(7) == 0) begin
         stall = $urandom_range(11, 1) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Run-length guard.
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Offer one point; returns at the edge where it is accepted.
   task automatic send_point(logic signed [CBITS-1:0] x, y, z, logic [TAG_BITS-1:0] tag,
                             logic last);
      if (!no_idle && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(11, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      req_z_coord <= z;
      req_tag     <= tag;
      req_last_in <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   // Wait until every expectation has arrived and the block has settled.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (kept_q.size() != 0 || !req_ready) @(posedge clock);
      repeat (1600) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_BITS'(idx) << 2;
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_COS_MIN: cfg_cos_lo = longint'($signed(val[COS_BITS-1:0]));
         REG_COS_MAX: cfg_cos_hi = longint'($signed(val[COS_BITS-1:0]));
         REG_WINDOW:  cfg_win    = int'(val[WIN_BITS-1:0]);
         default: ;
      endcase
   endtask

   task automatic set_config(int lo, int hi, int win);
      csr_write(REG_COS_MIN, CSR_DATA_BITS'(lo));
      csr_write(REG_COS_MAX, CSR_DATA_BITS'(hi));
      csr_write(REG_WINDOW, CSR_DATA_BITS'(win));
   endtask

   // One scan of len points; most points lie on a wall, some jump along a ray.
   task automatic send_scan(int len, int noise_pct);
      longint r, y0, step, x, y, z;
      int pick;
      r = $urandom_range(100000, 500);
      y0 = longint'($urandom_range(200000)) - 100000;
      step = $urandom_range(400, 1);
      x = r; y = y0; z = longint'($urandom_range(200)) - 100;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(99);
         if (pick < noise_pct) begin
            send_point(CBITS'($urandom), CBITS'($urandom), CBITS'($urandom),
                       TAG_BITS'($urandom), i == len - 1);
            continue;
         end
         pick = $urandom_range(9);
         if (pick == 0) begin
            x = x * 2 + 37;
            y = y * 2;
         end else if (pick == 1) begin
            x = x; // repeat the previous point
         end else begin
            y = y + step;
            x = x + longint'($urandom_range(6)) - 3;
         end
         send_point(CBITS'(x), CBITS'(y), CBITS'(z), TAG_BITS'($urandom), i == len - 1);
      end
   endtask

   // Directed: coordinate extremes, origin, duplicates and a lone point.
   task automatic test_extremes();
      set_config(32270, -32270, 2);
      send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF, 1'b0);
      send_point(-24'sh800000, 24'sh7FFFFF, -24'sh800000, 16'h0000, 1'b0);
      send_point(24'sd0, 24'sd0, 24'sd0, 16'h1234, 1'b0);
      send_point(24'sd1000, 24'sd0, 24'sd0, 16'h0001, 1'b0);
      send_point(24'sd1000, 24'sd0, 24'sd0, 16'h0002, 1'b0);
      send_point(24'sd1000, 24'sd50, 24'sd0, 16'h0003, 1'b0);
      send_point(-24'sh800000, -24'sh800000, -24'sh800000, 16'h8000, 1'b1);
      send_point(24'sd500, 24'sd7, -24'sd9, 16'hBEEF, 1'b1);
      wait_idle();
   endtask

   // Directed: window out of range and at its limits, cosine register extremes.
   task automatic test_limits();
      set_config(32767, -32768, 0);
      send_scan(4, 0);
      wait_idle();
      set_config(-32768, 32767, 9);
      send_scan(3, 0);
      wait_idle();
      set_config(32270, -32270, 15);
      send_scan(3, 0);
      wait_idle();
      set_config(0, 0, 1);
      send_scan(4, 0);
      wait_idle();
      set_config(30000, -30000, 8);
      send_scan(5, 0);
      wait_idle();
   endtask

   // Directed: a window write in mid scan applies only from the next scan.
   task automatic test_window_mid_scan();
      set_config(32270, -32270, 1);
      send_point(24'sd2000, 24'sd0, 24'sd0, 16'h0010, 1'b0);
      send_point(24'sd2000, 24'sd100, 24'sd0, 16'h0011, 1'b0);
      wait_idle();
      csr_write(REG_WINDOW, 32'd3);
      send_point(24'sd2000, 24'sd200, 24'sd0, 16'h0012, 1'b0);
      send_point(24'sd4000, 24'sd400, 24'sd0, 16'h0013, 1'b1);
      send_scan(5, 0);
      wait_idle();
   endtask

   // Long receiver hold-off while the sender keeps offering points.
   task automatic test_back_pressure();
      set_config(32270, -32270, 1);
      hold_len = 3000;
      hold_seq++;
      send_scan(14, 5);
      wait_idle();
   endtask

   // Random scans with occasional register changes between phases.
   task automatic test_random(int items);
      int sent, len, w;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(5) == 0 || sent == 0) begin
            wait_idle();
            w = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(3, 1);
            if ($urandom_range(3) == 0)
               set_config(int'($urandom_range(65535)) - 32768,
                          int'($urandom_range(65535)) - 32768, w);
            else
               set_config($urandom_range(32767, 25000), -int'($urandom_range(32767, 25000)), w);
         end
         len = ($urandom_range(7) == 0) ? $urandom_range(20, 10) : $urandom_range(8, 1);
         send_scan(len, 10);
         sent += len;
      end
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_x_coord = '0; req_y_coord = '0; req_z_coord = '0;
      req_tag = '0; req_last_in = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      errors = 0; cycles = 0; no_idle = 1'b0; hold_seq = 0; hold_len = 0;
      for (int k = 0; k < DEPTH; k++) begin
         ln_x[k] = '0; ln_y[k] = '0; ln_z[k] = '0; ln_tag[k] = '0;
      end
      held_cnt = 0; scan_win = 1;
      cfg_cos_lo = COS_MIN_RESET; cfg_cos_hi = COS_MAX_RESET; cfg_win = WINDOW_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_limits();
      test_window_mid_scan();
      test_back_pressure();
      test_random(300);
      no_idle = 1'b1;
      test_random(80);

      repeat (DRAIN) @(posedge clock);
      if (errors == 0 && kept_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, kept_q.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
